### design/mwgcd_pkg.sv
`default_nettype none
package mwgcd_pkg;
    localparam int NUM_WORDS_DEF = 32;
    localparam int WORD_W        = 32;

    // controller to datapath
    typedef struct packed {
        logic load;     // store input pair at load index
        logic clr_idx;  // restart the word index
        logic inc_idx;  // advance the word index
        logic op_start; // begin a word-serial pass
        logic [2:0] op; // pass kind
    } mwgcd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pass_done; // word-serial pass finished
        logic a_zero;
        logic b_zero;
        logic a_odd;
        logic b_odd;
        logic a_gt_b;
        logic idx_last;  // index at last loaded word
        logic full;      // load position at top of store
    } mwgcd_sts_t;

    // pass kinds
    localparam logic [2:0] OP_SCAN  = 3'd0; // zero/compare flags
    localparam logic [2:0] OP_SHRA  = 3'd1;
    localparam logic [2:0] OP_SHRB  = 3'd2;
    localparam logic [2:0] OP_SHRAB = 3'd3;
    localparam logic [2:0] OP_SWAP  = 3'd4;
    localparam logic [2:0] OP_SUB   = 3'd5; // b -= a
    localparam logic [2:0] OP_SHLA  = 3'd6;
    localparam logic [2:0] OP_COPYB = 3'd7; // a = b
endpackage
`default_nettype wire

### design/mwgcd_dp.sv
`default_nettype none
module mwgcd_dp #(
    parameter int NUM_WORDS = mwgcd_pkg::NUM_WORDS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire mwgcd_pkg::mwgcd_cmd_t  cmd,
    output mwgcd_pkg::mwgcd_sts_t       sts,
    input  wire logic [31:0]            a_word,
    input  wire logic [31:0]            b_word,
    output logic [31:0]                 out_word
);
    import mwgcd_pkg::*;
    localparam int IW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    logic [31:0] a_mem [NUM_WORDS];
    logic [31:0] b_mem [NUM_WORDS];
    logic [IW-1:0] len_reg, len_next;      // last loaded index
    logic [IW-1:0] idx_reg;                // pass index
    logic          busy_reg;
    logic [2:0]    op_reg;
    logic          dir_reg;                // 1: walk downward
    logic          carry_reg;              // borrow / shifted bit
    logic          carry2_reg;
    logic          az_reg, bz_reg, gt_reg, lt_reg;
    logic          done_reg;
    logic          nonempty_reg;           // a load happened since last clr
    logic [31:0]   ra, rb, wa, wb;
    logic          nc, nc2, we_a, we_b;
    logic [32:0]   diff;
    logic          pass_end;               // index at the last word of the walk

    assign ra = a_mem[idx_reg];
    assign rb = b_mem[idx_reg];
    assign diff = {1'b0, rb} - {1'b0, ra} - {32'd0, carry_reg};
    assign out_word = ra;
    assign pass_end = (dir_reg && idx_reg == '0) || (!dir_reg && idx_reg == len_reg);

    // per-word operation
    always_comb
    begin
        wa = ra; wb = rb; nc = carry_reg; nc2 = carry2_reg; we_a = 1'b0; we_b = 1'b0;
        unique case (op_reg)
            OP_SCAN:  ;
            OP_SHRA:  begin wa = {carry_reg, ra[31:1]}; nc = ra[0]; we_a = 1'b1; end
            OP_SHRB:  begin wb = {carry_reg, rb[31:1]}; nc = rb[0]; we_b = 1'b1; end
            OP_SHRAB: begin
                wa = {carry_reg, ra[31:1]}; nc = ra[0];
                wb = {carry2_reg, rb[31:1]}; nc2 = rb[0];
                we_a = 1'b1; we_b = 1'b1;
            end
            OP_SWAP:  begin wa = rb; wb = ra; we_a = 1'b1; we_b = 1'b1; end
            OP_SUB:   begin wb = diff[31:0]; nc = diff[32]; we_b = 1'b1; end
            OP_SHLA:  begin wa = {ra[30:0], carry_reg}; nc = ra[31]; we_a = 1'b1; end
            OP_COPYB: begin wa = rb; we_a = 1'b1; end
            default:  ;
        endcase
    end

    // operand stores
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_mem[len_next] <= a_word;
            b_mem[len_next] <= b_word;
        end
        else if (busy_reg)
        begin
            if (we_a) a_mem[idx_reg] <= wa;
            if (we_b) b_mem[idx_reg] <= wb;
        end
    end

    // load position: next free slot
    always_comb
    begin
        len_next = nonempty_reg ? len_reg + IW'(1) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0; idx_reg <= '0; busy_reg <= 1'b0; op_reg <= OP_SCAN;
            dir_reg <= 1'b0; carry_reg <= 1'b0; carry2_reg <= 1'b0;
            az_reg <= 1'b1; bz_reg <= 1'b1; gt_reg <= 1'b0; lt_reg <= 1'b0;
            done_reg <= 1'b0; nonempty_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && !cmd.op_start && pass_end;
            if (cmd.load)
            begin
                len_reg <= len_next;
                nonempty_reg <= 1'b1;
            end
            if (cmd.clr_idx)
            begin
                idx_reg <= '0;
                nonempty_reg <= 1'b0;
            end
            else if (cmd.inc_idx)
                idx_reg <= idx_reg + IW'(1);
            if (cmd.op_start)
            begin
                op_reg <= cmd.op;
                busy_reg <= 1'b1;
                carry_reg <= 1'b0; carry2_reg <= 1'b0;
                az_reg <= 1'b1; bz_reg <= 1'b1; gt_reg <= 1'b0; lt_reg <= 1'b0;
                // right shifts and compare walk from the top word
                priority if (cmd.op == OP_SHRA || cmd.op == OP_SHRB ||
                             cmd.op == OP_SHRAB || cmd.op == OP_SCAN)
                begin
                    dir_reg <= 1'b1; idx_reg <= len_reg;
                end
                else
                begin
                    dir_reg <= 1'b0; idx_reg <= '0;
                end
            end
            else if (busy_reg)
            begin
                carry_reg <= nc; carry2_reg <= nc2;
                if (ra != 32'd0) az_reg <= 1'b0;
                if (rb != 32'd0) bz_reg <= 1'b0;
                // first differing word from the top decides
                if (!gt_reg && !lt_reg)
                begin
                    gt_reg <= ra > rb;
                    lt_reg <= ra < rb;
                end
                if (pass_end)
                    busy_reg <= 1'b0;
                else
                    idx_reg <= dir_reg ? idx_reg - IW'(1) : idx_reg + IW'(1);
            end
        end
    end

    // status: odd bits read word 0 directly; after a scan idx sits at word 0
    assign sts.pass_done = done_reg;
    assign sts.a_zero    = az_reg;
    assign sts.b_zero    = bz_reg;
    assign sts.a_gt_b    = gt_reg;
    assign sts.a_odd     = a_mem[0][0];
    assign sts.b_odd     = b_mem[0][0];
    assign sts.idx_last  = (idx_reg == len_reg);
    assign sts.full      = (len_next == IW'(NUM_WORDS - 1));

`ifndef NO_ASSERTIONS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op_start |-> !busy_reg) else $error("pass started while busy");
    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !busy_reg) else $error("load during pass");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("done while busy");
`endif
endmodule
`default_nettype wire

### design/mwgcd_ctrl.sv
`default_nettype none
module mwgcd_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  final_in,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       final_out,
    output mwgcd_pkg::mwgcd_cmd_t      cmd,
    input  wire mwgcd_pkg::mwgcd_sts_t sts
);
    import mwgcd_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD, S_SCAN0, S_CHK0, S_PRE, S_PREW, S_AODD, S_AODDW,
        S_BEV, S_BEVW, S_CMP, S_CMPW, S_SWAPW, S_SUBW, S_SHL, S_OUT, S_OUTW
    } state_t;

    state_t      state_reg, state_next;
    logic [11:0] shift_reg, shift_next;   // shared-factor count
    logic        start_reg;               // pass in flight flag
    logic        in_acc, out_acc;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;
    assign in_stall = (state_reg != S_LOAD);
    assign out_valid = (state_reg == S_OUT);
    assign final_out = sts.idx_last;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        shift_next = shift_reg;
        cmd = '0;
        unique case (state_reg)
            S_LOAD:
                if (in_acc)
                begin
                    cmd.load = 1'b1;
                    if (final_in || sts.full)
                    begin
                        state_next = S_SCAN0;
                        shift_next = '0;
                    end
                end
            // scan starts once the last word and its index are stored
            S_SCAN0:
            begin
                cmd.op_start = 1'b1; cmd.op = OP_SCAN;
                state_next = S_CHK0;
            end
            S_CHK0:
                if (sts.pass_done)
                begin
                    if (sts.a_zero)
                    begin
                        cmd.op_start = 1'b1; cmd.op = OP_COPYB; state_next = S_SHL;
                        shift_next = '0;
                    end
                    else if (sts.b_zero)
                        state_next = S_PRE;
                    else
                        state_next = S_PRE;
                end
            S_PRE:
                if (sts.b_zero || sts.a_odd || sts.b_odd)
                    state_next = S_AODD;
                else
                begin
                    cmd.op_start = 1'b1; cmd.op = OP_SHRAB;
                    shift_next = shift_reg + 12'd1;
                    state_next = S_PREW;
                end
            S_PREW: if (sts.pass_done) state_next = S_PRE;
            S_AODD:
                if (sts.b_zero || sts.a_odd)
                    state_next = S_BEV;
                else
                begin
                    cmd.op_start = 1'b1; cmd.op = OP_SHRA; state_next = S_AODDW;
                end
            S_AODDW: if (sts.pass_done) state_next = S_AODD;
            S_BEV:
                if (sts.b_zero)
                begin
                    // restore shared factors of two, if any
                    if (shift_reg != '0)
                    begin
                        cmd.op_start = 1'b1; cmd.op = OP_SHLA; state_next = S_SHL;
                    end
                    else
                    begin
                        cmd.clr_idx = 1'b1; state_next = S_OUT;
                    end
                end
                else if (sts.b_odd)
                begin
                    cmd.op_start = 1'b1; cmd.op = OP_SCAN; state_next = S_CMPW;
                end
                else
                begin
                    cmd.op_start = 1'b1; cmd.op = OP_SHRB; state_next = S_BEVW;
                end
            S_BEVW: if (sts.pass_done) state_next = S_BEV;
            S_CMP: ;
            S_CMPW:
                if (sts.pass_done)
                begin
                    cmd.op_start = 1'b1;
                    if (sts.a_gt_b)
                    begin
                        cmd.op = OP_SWAP; state_next = S_SWAPW;
                    end
                    else
                    begin
                        cmd.op = OP_SUB; state_next = S_SUBW;
                    end
                end
            S_SWAPW:
                if (sts.pass_done)
                begin
                    cmd.op_start = 1'b1; cmd.op = OP_SUB; state_next = S_SUBW;
                end
            S_SUBW:
                if (sts.pass_done)
                begin
                    // rescan to refresh the zero flag of b
                    cmd.op_start = 1'b1; cmd.op = OP_SCAN; state_next = S_OUTW;
                end
            S_OUTW:
                if (sts.pass_done)
                    state_next = S_BEV;
            S_SHL:
                // a shift pass, or for a zero a the copy of b, was started on entry when the count allows
                if (sts.pass_done || start_reg == 1'b0)
                begin
                    if (shift_reg != '0 && sts.pass_done)
                        shift_next = shift_reg - 12'd1;
                    if ((sts.pass_done && shift_reg > 12'd1))
                    begin
                        cmd.op_start = 1'b1; cmd.op = OP_SHLA;
                    end
                    else
                    begin
                        cmd.clr_idx = 1'b1; state_next = S_OUT;
                    end
                end
            S_OUT:
                if (out_acc)
                begin
                    if (sts.idx_last)
                    begin
                        cmd.clr_idx = 1'b1; state_next = S_LOAD;
                    end
                    else
                        cmd.inc_idx = 1'b1;
                end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            shift_reg <= '0;
            start_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            shift_reg <= shift_next;
            if (cmd.op_start) start_reg <= 1'b1;
            else if (sts.pass_done) start_reg <= 1'b0;
        end
    end

`ifndef NO_ASSERTIONS
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("input open while output");
    a_out_after: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && final_out) |=> state_reg == S_LOAD) else $error("no return to load");
    a_load_only: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == S_LOAD) else $error("load outside load state");
`endif
endmodule
`default_nettype wire

### design/multiword_gcd.sv
`default_nettype none
// channel | signals                                   | direction
// input   | in_valid, in_stall, a_word, b_word, final_in | into block
// output  | out_valid, out_stall, gcd_word, final_out  | out of block
// One word pair is taken per cycle while loading; the final pair starts the gcd
// in the cycle after it is taken. Binary gcd runs as word-serial passes over the operand
// store, and the controller rechecks the low bits between shift passes; the pass
// count scales with the operand bit length.
// Reset clears the controller; operand stores hold no reset value.
// Output words are held stable while out_stall is high; input stalls during work.
module multiword_gcd #(
    parameter int NUM_WORDS = mwgcd_pkg::NUM_WORDS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] a_word,
    input  wire logic [31:0] b_word,
    input  wire logic        final_in,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      gcd_word,
    output logic             final_out
);
    import mwgcd_pkg::*;

    mwgcd_cmd_t cmd;
    mwgcd_sts_t sts;

    mwgcd_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .final_in(final_in), .out_valid(out_valid), .out_stall(out_stall),
        .final_out(final_out), .cmd(cmd), .sts(sts)
    );

    mwgcd_dp #(.NUM_WORDS(NUM_WORDS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .a_word(a_word), .b_word(b_word), .out_word(gcd_word)
    );
endmodule
`default_nettype wire

### dv/gcd_checker.sv
`timescale 1ns / 1ps
module gcd_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [31:0] a_word,
    input  wire logic [31:0] b_word,
    input  wire logic        final_in,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [31:0] gcd_word,
    input  wire logic        final_out,
    output int               errors,
    output int               pending
);
    localparam int MAX_WORDS = 32;

    logic [31:0] a_store [MAX_WORDS];
    logic [31:0] b_store [MAX_WORDS];
    int          fill;
    logic [31:0] gcd_words_q [$];
    logic        gcd_last_q [$];

    // binary gcd on zero-padded wide values; padding leaves the gcd unchanged
    function automatic logic [1023:0] wide_gcd(input logic [1023:0] a, input logic [1023:0] b);
        logic [1023:0] t;
        int            sh;
        sh = 0;
        if (a == '0)
            return b;
        if (b == '0)
            return a;
        while (a[0] == 1'b0 && b[0] == 1'b0)
        begin
            a = a >> 1;
            b = b >> 1;
            sh++;
        end
        while (a[0] == 1'b0)
            a = a >> 1;
        while (b != '0)
        begin
            while (b[0] == 1'b0)
                b = b >> 1;
            if (a > b)
            begin
                t = a;
                a = b;
                b = t;
            end
            b = b - a;
        end
        return a << sh;
    endfunction

    assign pending = gcd_words_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic [1023:0] wa, wb, g;
        int            n;
        if (!rst_n)
        begin
            fill   <= 0;
            errors <= 0;
            gcd_words_q.delete();
            gcd_last_q.delete();
        end
        else
        begin
            // input transfer: store pair, predict on final or full store
            if (in_valid && !in_stall)
            begin
                a_store[fill] = a_word;
                b_store[fill] = b_word;
                if (final_in || fill == MAX_WORDS - 1)
                begin
                    n  = fill + 1;
                    wa = '0;
                    wb = '0;
                    for (int i = 0; i < n; i++)
                    begin
                        wa[i*32 +: 32] = a_store[i];
                        wb[i*32 +: 32] = b_store[i];
                    end
                    g = wide_gcd(wa, wb);
                    for (int i = 0; i < n; i++)
                    begin
                        gcd_words_q.push_back(g[i*32 +: 32]);
                        gcd_last_q.push_back(i == n - 1);
                    end
                    fill <= 0;
                end
                else
                    fill <= fill + 1;
            end
            // output transfer: compare with oldest expected word
            if (out_valid && !out_stall)
            begin
                if (gcd_words_q.size() == 0)
                begin
                    $display("%0t: unexpected result word %h last %b", $time,
                             gcd_word, final_out);
                    errors <= errors + 1;
                end
                else
                begin
                    if (gcd_word !== gcd_words_q[0] || final_out !== gcd_last_q[0])
                    begin
                        $display("%0t: gcd word expected %h last %b, got %h last %b",
                                 $time, gcd_words_q[0], gcd_last_q[0], gcd_word, final_out);
                        errors <= errors + 1;
                    end
                    void'(gcd_words_q.pop_front());
                    void'(gcd_last_q.pop_front());
                end
            end
        end
    end
endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    localparam int ITEM_TARGET = 430;
    localparam int CYCLE_LIMIT = 30_000_000;

    typedef enum int {K_RAND, K_SHARED, K_AZERO, K_BZERO, K_EQUAL, K_SPARSE, K_ONES} op_kind_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] a_word;
    logic [31:0] b_word;
    logic        final_in;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] gcd_word;
    logic        final_out;
    int          errors;
    int          pending;
    int          items_sent;
    int          src_pct;
    int          snk_pct;
    int          cycles;

    multiword_gcd u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .a_word(a_word), .b_word(b_word), .final_in(final_in),
        .out_valid(out_valid), .out_stall(out_stall),
        .gcd_word(gcd_word), .final_out(final_out)
    );

    gcd_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .a_word(a_word), .b_word(b_word), .final_in(final_in),
        .out_valid(out_valid), .out_stall(out_stall),
        .gcd_word(gcd_word), .final_out(final_out),
        .errors(errors), .pending(pending)
    );

    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // receiver stall
    always @(posedge clk)
        out_stall <= rst_n && ($urandom_range(99) < snk_pct);

    // hang guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic [1023:0] rand_bits(input int nbits);
        logic [1023:0] v;
        for (int i = 0; i < 32; i++)
            v[i*32 +: 32] = $urandom;
        if (nbits <= 0)
            return '0;
        if (nbits < 1024)
            v &= (1024'b1 << nbits) - 1;
        return v;
    endfunction

    // one word-pair transfer, with an optional sender gap before it
    task automatic send_pair(input logic [31:0] a, input logic [31:0] b, input logic last);
        bit took;
        if ($urandom_range(99) < src_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        a_word   <= a;
        b_word   <= b;
        final_in <= last;
        do
        begin
            @(negedge clk);
            took = !in_stall;
            @(posedge clk);
        end
        while (!took);
        items_sent++;
    endtask

    // one operand load of n words; mark_last=0 relies on the full-store rule
    task automatic run_gcd(input int n, input op_kind_t kind, input bit mark_last);
        logic [1023:0] a, b, g;
        int            gw, sh, xbits;
        gw    = (n == 1) ? 12 : 32;
        sh    = $urandom_range(0, 6);
        xbits = n * 32 - gw - sh;
        case (kind)
            K_RAND:   begin a = rand_bits(n * 32); b = rand_bits(n * 32); end
            K_SHARED:
            begin
                g = rand_bits(gw) << sh;
                a = g * rand_bits(xbits);
                b = g * rand_bits(xbits);
            end
            K_AZERO:  begin a = '0; b = rand_bits($urandom_range(1, n * 32)); end
            K_BZERO:  begin a = rand_bits($urandom_range(1, n * 32)); b = '0; end
            K_EQUAL:  begin a = rand_bits(n * 32); b = a; end
            K_SPARSE:
            begin
                a = 1024'b1 << $urandom_range(0, n * 32 - 1);
                b = rand_bits($urandom_range(1, 8)) << $urandom_range(0, n * 32 - 8);
            end
            default:  begin a = rand_bits(n * 32); b = ~'0; end
        endcase
        for (int i = 0; i < n; i++)
            send_pair(a[i*32 +: 32], b[i*32 +: 32], mark_last && (i == n - 1));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        bit big_a, big_b;
        int n;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        a_word     = '0;
        b_word     = '0;
        final_in   = 1'b0;
        out_stall  = 1'b0;
        cycles     = 0;
        items_sent = 0;
        src_pct    = 13;
        snk_pct    = 47;
        big_a      = 1'b0;
        big_b      = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single-word extremes, zero operands, multiword shapes
        send_pair(32'h0, 32'h0, 1'b1);
        send_pair(32'h0, 32'hffff_ffff, 1'b1);
        send_pair(32'hffff_ffff, 32'h0, 1'b1);
        send_pair(32'hffff_ffff, 32'hffff_ffff, 1'b1);
        send_pair(32'h1, 32'hffff_fffe, 1'b1);
        send_pair(32'h8000_0000, 32'hc000_0000, 1'b1);
        run_gcd(1, K_SHARED, 1'b1);
        run_gcd(2, K_SHARED, 1'b1);
        run_gcd(2, K_AZERO, 1'b1);
        run_gcd(2, K_BZERO, 1'b1);
        run_gcd(2, K_SPARSE, 1'b1);
        run_gcd(2, K_EQUAL, 1'b1);
        run_gcd(3, K_ONES, 1'b1);

        // sender holds off until every result is out
        drain();

        // random loads, mostly short; two full-store loads along the way
        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= 290)
            begin
                src_pct = 0;
                snk_pct = 0;
            end
            else if (items_sent >= 150)
            begin
                src_pct = 47;
                snk_pct = 13;
            end
            if (!big_a && items_sent >= 200)
            begin
                big_a = 1'b1;
                run_gcd(32, K_SHARED, 1'b0);
            end
            else if (!big_b && items_sent >= 350)
            begin
                big_b = 1'b1;
                run_gcd(32, K_RAND, 1'b1);
            end
            else
            begin
                n = ($urandom_range(9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
                run_gcd(n, op_kind_t'($urandom_range(6)), 1'b1);
            end
        end

        drain();
        repeat (200) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
